>>> rtl/ssv_pkg.sv
// Shared types and constants for the stepper stall supervisor.
// Used by every module in rtl/; depends on nothing.
package ssv_pkg;

   localparam int LOAD_W   = 10;
   localparam int THR_W    = 7;
   localparam int TIME_W   = 24;
   localparam int SETTLE_W = 16;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REG_IDX_W = 3;

   typedef enum logic [1:0] {
      FUNC_SAMPLE,
      FUNC_POLL,
      FUNC_START,
      FUNC_STOP
   } func_type;

   localparam logic [REG_IDX_W-1:0] REG_BASE_THRESHOLD    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LOAD_MAX          = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SETTLE_MS         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STALL_STOP_ENABLE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_USE_AVERAGE       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ADAPT_ENABLE      = 3'd5;

   localparam logic [LOAD_W-1:0]       LOAD_MAX_RESET = 10'd150;
   localparam int                      AVG_LOW        = 10;
   localparam logic [1:0]              OVER_SAT       = 2'd3;
   localparam logic signed [THR_W-1:0] THR_FLOOR      = -7'sd60;
   localparam logic [2:0]              HIST_FULL      = 3'b111;

   typedef struct packed {
      logic signed [THR_W-1:0] base_threshold;
      logic [LOAD_W-1:0]       load_max;
      logic [SETTLE_W-1:0]     settle_ms;
      logic                    stall_stop_enable;
      logic                    use_average;
      logic                    adapt_enable;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic signed [THR_W-1:0] value;
   } thr_set_type;

   typedef struct packed {
      logic              over_max;
      logic              under_min;
      logic [LOAD_W-1:0] average;
   } avg_stat_type;

   typedef struct packed {
      func_type          func;
      logic              sample_zero;
      logic              open_now;
      logic              running;
      logic              moving;
      logic [TIME_W-1:0] elapsed_ms;
      logic              guard_enable;
   } item_type;

   typedef struct packed {
      logic                    stalled;
      logic                    disconnected;
      logic signed [THR_W-1:0] threshold;
      logic signed [THR_W-1:0] threshold_at_stall;
   } guard_res_type;

endpackage

>>> rtl/stepper_stall_supervisor.sv
// Stepper stall supervisor top level: handshake, result register and the
// csr, window and guard units. Depends on ssv_pkg, ssv_csr, ssv_avg, ssv_guard.
//
// Takes one transaction per clock and presents its result in the output
// register on the following cycle; a new transaction is taken while the
// previous result is being handed off, so throughput is one per cycle unless
// the result side holds rsp_stall. Each transaction is resolved in a single
// pass from the state registers and the registered read of the sample window
// memory (AVG_DEPTH entries). The window needs no clearing after reset: the
// first load sample stands in for every entry until it is overwritten.
module stepper_stall_supervisor
   import ssv_pkg::*;
#(
   parameter int AVG_DEPTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [LOAD_W-1:0]       req_load_sample,
   input  logic                    req_open_a,
   input  logic                    req_open_b,
   input  logic                    req_running,
   input  logic                    req_moving,
   input  logic [TIME_W-1:0]       req_elapsed_ms,
   input  logic                    req_guard_enable,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_stalled,
   output logic                    rsp_disconnected,
   output logic signed [THR_W-1:0] rsp_threshold,
   output logic [LOAD_W-1:0]       rsp_load_average,
   output logic signed [THR_W-1:0] rsp_threshold_at_stall,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   logic                    accept;
   logic                    rsp_valid_ff;
   logic                    stalled_ff;
   logic                    disc_ff;
   logic signed [THR_W-1:0] thr_ff;
   logic [LOAD_W-1:0]       avg_ff;
   logic signed [THR_W-1:0] thr_stall_ff;
   cfg_type                 cfg;
   thr_set_type             thr_set;
   avg_stat_type            stat;
   item_type                item;
   guard_res_type           res;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign item.func         = func_type'(req_func);
   assign item.sample_zero  = (req_load_sample == '0);
   assign item.open_now     = req_open_a || req_open_b;
   assign item.running      = req_running;
   assign item.moving       = req_moving;
   assign item.elapsed_ms   = req_elapsed_ms;
   assign item.guard_enable = req_guard_enable;

   ssv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .thr_set (thr_set)
   );

   ssv_avg #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_avg (
      .clock     (clock),
      .reset     (reset),
      .sample_en (accept && (item.func == FUNC_SAMPLE)),
      .sample    (req_load_sample),
      .load_max  (cfg.load_max),
      .stat      (stat)
   );

   ssv_guard u_guard (
      .clock   (clock),
      .reset   (reset),
      .item_en (accept),
      .item    (item),
      .cfg     (cfg),
      .thr_set (thr_set),
      .stat    (stat),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stalled_ff   <= res.stalled;
         disc_ff      <= res.disconnected;
         thr_ff       <= res.threshold;
         avg_ff       <= stat.average;
         thr_stall_ff <= res.threshold_at_stall;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_stalled            = stalled_ff;
   assign rsp_disconnected       = disc_ff;
   assign rsp_threshold          = thr_ff;
   assign rsp_load_average       = avg_ff;
   assign rsp_threshold_at_stall = thr_stall_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_stall_not_disc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stalled) |-> !rsp_disconnected)
      else $error("stall and disconnect reported together");

   a_stall_threshold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stalled) |-> (rsp_threshold == rsp_threshold_at_stall))
      else $error("threshold after stall differs from recorded value");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");
`endif

endmodule

>>> rtl/ssv_csr.sv
// Configuration register file with an APB-style write/read port.
// Depends on ssv_pkg.
module ssv_csr
   import ssv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg,
   output thr_set_type       thr_set
);

   logic signed [THR_W-1:0] base_ff;
   logic [LOAD_W-1:0]       load_max_ff;
   logic [SETTLE_W-1:0]     settle_ff;
   logic                    stall_stop_ff;
   logic                    use_avg_ff;
   logic                    adapt_ff;
   logic                    wr_en;
   logic [REG_IDX_W-1:0]    idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         load_max_ff   <= LOAD_MAX_RESET;
         settle_ff     <= '0;
         stall_stop_ff <= 1'b0;
         use_avg_ff    <= 1'b0;
         adapt_ff      <= 1'b1;
      end else if (wr_en) begin
         case (idx)
            REG_BASE_THRESHOLD:    base_ff       <= pwdata[THR_W-1:0];
            REG_LOAD_MAX:          load_max_ff   <= pwdata[LOAD_W-1:0];
            REG_SETTLE_MS:         settle_ff     <= pwdata[SETTLE_W-1:0];
            REG_STALL_STOP_ENABLE: stall_stop_ff <= pwdata[0];
            REG_USE_AVERAGE:       use_avg_ff    <= pwdata[0];
            REG_ADAPT_ENABLE:      adapt_ff      <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_BASE_THRESHOLD:    prdata = {{(DATA_W-THR_W){1'b0}}, base_ff};
         REG_LOAD_MAX:          prdata = {{(DATA_W-LOAD_W){1'b0}}, load_max_ff};
         REG_SETTLE_MS:         prdata = {{(DATA_W-SETTLE_W){1'b0}}, settle_ff};
         REG_STALL_STOP_ENABLE: prdata = {{(DATA_W-1){1'b0}}, stall_stop_ff};
         REG_USE_AVERAGE:       prdata = {{(DATA_W-1){1'b0}}, use_avg_ff};
         REG_ADAPT_ENABLE:      prdata = {{(DATA_W-1){1'b0}}, adapt_ff};
         default:               prdata = '0;
      endcase
   end

   assign cfg.base_threshold    = base_ff;
   assign cfg.load_max          = load_max_ff;
   assign cfg.settle_ms         = settle_ff;
   assign cfg.stall_stop_enable = stall_stop_ff;
   assign cfg.use_average       = use_avg_ff;
   assign cfg.adapt_enable      = adapt_ff;

   assign thr_set.valid = wr_en && (idx == REG_BASE_THRESHOLD);
   assign thr_set.value = pwdata[THR_W-1:0];

endmodule

>>> rtl/ssv_avg.sv
// Moving-average window: sample memory, running sum, average by reciprocal
// multiply and the load limit compares. Depends on ssv_pkg.
module ssv_avg
   import ssv_pkg::*;
#(
   parameter int AVG_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sample_en,
   input  logic [LOAD_W-1:0] sample,
   input  logic [LOAD_W-1:0] load_max,
   output avg_stat_type      stat
);

   localparam int LOG_D   = $clog2(AVG_DEPTH);
   localparam int POS_W   = (AVG_DEPTH > 1) ? LOG_D : 1;
   localparam int SUM_W   = LOAD_W + LOG_D;
   localparam int SHIFT   = SUM_W + LOG_D;
   localparam int RECIP   = (2 ** SHIFT) / AVG_DEPTH + 1;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int LIM_W   = SUM_W + 1;

   logic [LOAD_W-1:0] window [AVG_DEPTH];
   logic [LOAD_W-1:0] rd_data_ff;
   logic [LOAD_W-1:0] prime_ff;
   logic              primed_ff, primed_in;
   logic              first_lap_ff, first_lap_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [LOAD_W-1:0] avg_ff, avg_in;
   logic [LOAD_W-1:0] oldest;
   logic [POS_W:0]    pos_inc;
   logic [POS_W-1:0]  pos_wrap;
   logic [POS_W-1:0]  wr_addr;
   logic [PROD_W-1:0] avg_prod;
   logic [LIM_W-1:0]  over_limit;

   assign oldest   = first_lap_ff ? prime_ff : rd_data_ff;
   assign pos_inc  = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign pos_wrap = (pos_inc == (POS_W+1)'(AVG_DEPTH)) ? '0 : pos_inc[POS_W-1:0];

   always_comb begin
      primed_in    = primed_ff;
      first_lap_in = first_lap_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      wr_addr      = pos_ff;
      if (sample_en) begin
         primed_in = 1'b1;
         if (!primed_ff) begin
            sum_in       = SUM_W'(sample) * SUM_W'(AVG_DEPTH);
            wr_addr      = '0;
            pos_in       = (AVG_DEPTH > 1) ? POS_W'(1) : '0;
            first_lap_in = (AVG_DEPTH > 1);
         end else begin
            sum_in       = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
            pos_in       = pos_wrap;
            first_lap_in = first_lap_ff && (pos_wrap != '0);
         end
      end
   end

   assign avg_prod   = PROD_W'(sum_in) * PROD_W'(RECIP_W'(RECIP));
   assign avg_in     = sample_en ? avg_prod[SHIFT +: LOAD_W] : avg_ff;
   assign over_limit = (LIM_W'(load_max) + LIM_W'(1)) * LIM_W'(AVG_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         first_lap_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
      end else begin
         primed_ff    <= primed_in;
         first_lap_ff <= first_lap_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_en) begin
         window[wr_addr] <= sample;
         if (!primed_ff) begin
            prime_ff <= sample;
         end
      end
      if (sample_en && (wr_addr == pos_in)) begin
         rd_data_ff <= sample;
      end else begin
         rd_data_ff <= window[pos_in];
      end
   end

   assign stat.over_max  = {1'b0, sum_in} >= over_limit;
   assign stat.under_min = sum_in < SUM_W'(AVG_LOW * AVG_DEPTH);
   assign stat.average   = avg_in;

endmodule

>>> rtl/ssv_guard.sv
// Stall guard control: threshold adaptation, stall detection and open-load
// history. Depends on ssv_pkg.
module ssv_guard
   import ssv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_en,
   input  item_type      item,
   input  cfg_type       cfg,
   input  thr_set_type   thr_set,
   input  avg_stat_type  stat,
   output guard_res_type res
);

   logic signed [THR_W-1:0] live_ff, live_in;
   logic signed [THR_W-1:0] saved_ff, saved_in;
   logic [1:0]              over_ff, over_in;
   logic [1:0]              over_inc;
   logic [2:0]              hist_ff, hist_in;
   logic                    guard_ff, guard_in;
   logic                    stalled;
   logic                    disc;

   assign over_inc = (over_ff == OVER_SAT) ? OVER_SAT : over_ff + 2'd1;

   always_comb begin
      live_in  = live_ff;
      saved_in = saved_ff;
      over_in  = over_ff;
      hist_in  = hist_ff;
      guard_in = guard_ff;
      stalled  = 1'b0;
      disc     = 1'b0;
      if (thr_set.valid) begin
         live_in = thr_set.value;
      end else if (item_en) begin
         case (item.func)
            FUNC_SAMPLE: begin
               if (guard_ff && item.running) begin
                  hist_in = {hist_ff[1:0], item.open_now};
                  if (item.elapsed_ms > TIME_W'(cfg.settle_ms)) begin
                     over_in = over_inc;
                     if (cfg.adapt_enable && (over_inc == OVER_SAT) && stat.over_max
                         && (live_ff > THR_FLOOR)) begin
                        live_in = live_ff - 7'sd1;
                        over_in = '0;
                     end
                     if (cfg.stall_stop_enable &&
                         (cfg.use_average ? stat.under_min : item.sample_zero)) begin
                        stalled  = 1'b1;
                        live_in  = cfg.base_threshold;
                        guard_in = 1'b0;
                        saved_in = cfg.base_threshold;
                     end
                  end
               end
            end
            FUNC_POLL: begin
               if (!guard_ff && item.moving) begin
                  hist_in = {1'b1, hist_ff[0], item.open_now};
               end
            end
            FUNC_START: guard_in = item.guard_enable;
            FUNC_STOP: begin
               live_in  = cfg.base_threshold;
               guard_in = 1'b0;
            end
            default: ;
         endcase
         if (!stalled && (hist_in == HIST_FULL)) begin
            hist_in = '0;
            disc    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         saved_ff <= '0;
         over_ff  <= '0;
         hist_ff  <= '0;
         guard_ff <= 1'b0;
      end else begin
         live_ff  <= live_in;
         saved_ff <= saved_in;
         over_ff  <= over_in;
         hist_ff  <= hist_in;
         guard_ff <= guard_in;
      end
   end

   assign res.stalled            = stalled;
   assign res.disconnected       = disc;
   assign res.threshold          = live_in;
   assign res.threshold_at_stall = saved_in;

endmodule
